// ===== rtl/assert_macros.svh =====
// Assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent must hold in the same cycle
`define ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion name failed");

// Antecedent holds, consequent must hold in the following cycle
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion name failed");

`endif

// ===== rtl/wlt_pkg.sv =====
// Shared types, widths and codes of the windowed loudness trigger
package wlt_pkg;

    // Field widths
    localparam int ENERGY_W  = 46;
    localparam int SAMPLES_W = 16;
    localparam int LEVEL_W   = 31;
    localparam int WARMUP_W  = 21;
    localparam int CAUSE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF  = 30;
    localparam int PACKET_SAMPLES_DEF = 48000;

    // Register reset values: peak -20 dB, moderate -31 dB (Q1.30)
    localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RST     = 31'd10737418;
    localparam logic [LEVEL_W-1:0] MODERATE_LEVEL_RST = 31'd852903;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 2'd2;

    // Fire causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_PEAK = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LONG = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // take input word, write ring slot, form peak product
        logic sweep;    // issue one ring read
        logic mul;      // form long-term product and warm-up flag
        logic decide;   // load result register, clear energies on fire
    } wlt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;   // current read is the last ring slot
        logic out_free;     // result register can take a new word
    } wlt_status_t;

endpackage

// ===== rtl/wlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module wlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wlt_ctrl.sv =====
// Sequencing controller: accept, ring sweep, multiply, decide
module wlt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wlt_pkg::wlt_status_t status,
    output wlt_pkg::wlt_cmd_t    cmd
);
    import wlt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_MUL,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read data is summed here
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/wlt_datapath.sv =====
// Ring storage, window sums, threshold products and result register
module wlt_datapath #(
    parameter int HISTORY_DEPTH  = wlt_pkg::HISTORY_DEPTH_DEF,
    parameter int PACKET_SAMPLES = wlt_pkg::PACKET_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wlt_pkg::wlt_cmd_t               cmd,
    output wlt_pkg::wlt_status_t            status,
    input  logic [wlt_pkg::ENERGY_W-1:0]    in_energy,
    input  logic [wlt_pkg::SAMPLES_W-1:0]   in_samples,
    input  logic [wlt_pkg::LEVEL_W-1:0]     peak_level,
    input  logic [wlt_pkg::LEVEL_W-1:0]     moderate_level,
    input  logic [wlt_pkg::WARMUP_W-1:0]    warmup,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_fire,
    output logic [wlt_pkg::CAUSE_W-1:0]     out_cause,
    output logic                            out_warm
);
    import wlt_pkg::*;

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int RAM_W  = ENERGY_W + SAMPLES_W;
    localparam int STOT_W = SAMPLES_W + IDX_W;
    localparam int ETOT_W = ENERGY_W + IDX_W;
    localparam int PPK_W  = LEVEL_W + SAMPLES_W;
    localparam int PMOD_W = LEVEL_W + STOT_W;
    localparam int CMP_W  = (ETOT_W > PMOD_W) ? ETOT_W : PMOD_W;
    localparam int WCMP_W = (STOT_W > WARMUP_W) ? STOT_W : WARMUP_W;
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [SAMPLES_W-1:0] SAMP_MAX = SAMPLES_W'(PACKET_SAMPLES);

    // Control state
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [IDX_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     rd_pend_reg;
    logic [HISTORY_DEPTH-1:0] e_valid_reg, e_valid_next;
    logic [HISTORY_DEPTH-1:0] s_valid_reg, s_valid_next;
    logic                     out_valid_reg, out_valid_next;

    // Payload
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic                samp_nz_reg, samp_nz_next;
    logic [PPK_W-1:0]    prod_pk_reg, prod_pk_next;
    logic [ETOT_W-1:0]   tot_e_reg, tot_e_next;
    logic [STOT_W-1:0]   tot_s_reg, tot_s_next;
    logic [PMOD_W-1:0]   prod_mod_reg, prod_mod_next;
    logic                warm_reg, warm_next;
    logic                out_fire_reg, out_fire_next;
    logic [CAUSE_W-1:0]  out_cause_reg, out_cause_next;
    logic                out_warm_reg, out_warm_next;

    logic [SAMPLES_W-1:0] samp_sat;
    logic [RAM_W-1:0]     ram_q;
    logic [ENERGY_W-1:0]  rd_energy;
    logic [SAMPLES_W-1:0] rd_samp;
    logic [CAUSE_W-1:0]   cause;

    // Oversized packets saturate to the nominal packet length
    assign samp_sat  = (in_samples > SAMP_MAX) ? SAMP_MAX : in_samples;
    assign rd_energy = ram_q[ENERGY_W-1:0];
    assign rd_samp   = ram_q[RAM_W-1:ENERGY_W];

    wlt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (slot_reg),
        .wdata ({samp_sat, in_energy}),
        .re    (cmd.sweep),
        .raddr (rd_cnt_reg),
        .rdata (ram_q)
    );

    // Decision: packet peak first, then long-term window
    always_comb
    begin
        cause = CAUSE_NONE;
        if (warm_reg)
        begin
            if (samp_nz_reg && ({1'b0, energy_reg} >= prod_pk_reg))
            begin
                cause = CAUSE_PEAK;
            end
            else if ((tot_s_reg != '0) && (CMP_W'(tot_e_reg) >= CMP_W'(prod_mod_reg)))
            begin
                cause = CAUSE_LONG;
            end
        end
    end

    assign status.sweep_last = (rd_cnt_reg == LAST_IDX);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Next-state logic
    always_comb
    begin
        slot_next      = slot_reg;
        rd_cnt_next    = rd_cnt_reg;
        e_valid_next   = e_valid_reg;
        s_valid_next   = s_valid_reg;
        out_valid_next = out_valid_reg;
        energy_next    = energy_reg;
        samp_nz_next   = samp_nz_reg;
        prod_pk_next   = prod_pk_reg;
        tot_e_next     = tot_e_reg;
        tot_s_next     = tot_s_reg;
        prod_mod_next  = prod_mod_reg;
        warm_next      = warm_reg;
        out_fire_next  = out_fire_reg;
        out_cause_next = out_cause_reg;
        out_warm_next  = out_warm_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // take the word and write its slot
        if (cmd.load)
        begin
            energy_next            = in_energy;
            samp_nz_next           = (samp_sat != '0);
            prod_pk_next           = PPK_W'(peak_level) * PPK_W'(samp_sat);
            e_valid_next[slot_reg] = 1'b1;
            s_valid_next[slot_reg] = 1'b1;
            slot_next              = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
            rd_cnt_next            = '0;
            tot_e_next             = '0;
            tot_s_next             = '0;
        end

        if (cmd.sweep)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end

        // sum the slot read in the previous cycle; never-written slots read as zero
        if (rd_pend_reg)
        begin
            tot_e_next = tot_e_reg + (e_valid_reg[rd_idx_reg] ? ETOT_W'(rd_energy) : '0);
            tot_s_next = tot_s_reg + (s_valid_reg[rd_idx_reg] ? STOT_W'(rd_samp) : '0);
        end

        if (cmd.mul)
        begin
            prod_mod_next = PMOD_W'(moderate_level) * PMOD_W'(tot_s_reg);
            warm_next     = (WCMP_W'(tot_s_reg) >= WCMP_W'(warmup));
        end

        // result word; a firing clears every stored energy
        if (cmd.decide)
        begin
            out_valid_next = 1'b1;
            out_fire_next  = (cause != CAUSE_NONE);
            out_cause_next = cause;
            out_warm_next  = warm_reg;
            if (cause != CAUSE_NONE)
            begin
                e_valid_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            e_valid_reg   <= '0;
            s_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= cmd.sweep;
            e_valid_reg   <= e_valid_next;
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_cnt_reg;
        energy_reg    <= energy_next;
        samp_nz_reg   <= samp_nz_next;
        prod_pk_reg   <= prod_pk_next;
        tot_e_reg     <= tot_e_next;
        tot_s_reg     <= tot_s_next;
        prod_mod_reg  <= prod_mod_next;
        warm_reg      <= warm_next;
        out_fire_reg  <= out_fire_next;
        out_cause_reg <= out_cause_next;
        out_warm_reg  <= out_warm_next;
    end

    assign out_valid = out_valid_reg;
    assign out_fire  = out_fire_reg;
    assign out_cause = out_cause_reg;
    assign out_warm  = out_warm_reg;

endmodule

// ===== rtl/windowed_loudness_trigger_core.sv =====
// An accepted input word passes through the ring sweep, drain, multiply and decide states
// before its result word is valid; decide waits while the previous result is not yet taken.
// One word is in work at a time: the next is taken only back in the idle state, as the
// ring sweep runs through the single read port of the history RAM.
// The result register lets the next word in while a result waits to be taken.
// Reset: registers go to defaults, ring valid bits clear so the ring reads as zero,
// write slot returns to zero.
module windowed_loudness_trigger_core #(
    parameter int HISTORY_DEPTH  = wlt_pkg::HISTORY_DEPTH_DEF,
    parameter int PACKET_SAMPLES = wlt_pkg::PACKET_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // packet_energy[45:0], packet_samples[61:46]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // fire[0], fire_cause[2:1], warmed_up[3]
    // configuration writes
    input  logic                            cfg_we,
    input  logic [wlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wlt_pkg::LEVEL_W-1:0]     cfg_data
);
    import wlt_pkg::*;

    localparam logic [WARMUP_W-1:0] WARMUP_RST = WARMUP_W'(3 * PACKET_SAMPLES);

    logic [LEVEL_W-1:0]  peak_level_reg;
    logic [LEVEL_W-1:0]  moderate_level_reg;
    logic [WARMUP_W-1:0] warmup_reg;

    wlt_cmd_t    cmd;
    wlt_status_t status;

    logic               out_fire;
    logic [CAUSE_W-1:0] out_cause;
    logic               out_warm;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_level_reg     <= PEAK_LEVEL_RST;
            moderate_level_reg <= MODERATE_LEVEL_RST;
            warmup_reg         <= WARMUP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEAK:     peak_level_reg     <= cfg_data;
                CFG_MODERATE: moderate_level_reg <= cfg_data;
                CFG_WARMUP:   warmup_reg         <= cfg_data[WARMUP_W-1:0];
                default:      ;
            endcase
        end
    end

    wlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wlt_datapath #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .PACKET_SAMPLES (PACKET_SAMPLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_energy      (s_tdata[ENERGY_W-1:0]),
        .in_samples     (s_tdata[ENERGY_W+SAMPLES_W-1:ENERGY_W]),
        .peak_level     (peak_level_reg),
        .moderate_level (moderate_level_reg),
        .warmup         (warmup_reg),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_fire       (out_fire),
        .out_cause      (out_cause),
        .out_warm       (out_warm)
    );

    assign m_tdata = {4'b0000, out_warm, out_cause, out_fire};

    `include "assert_macros.svh"

    // a firing word is always a warmed-up word with a non-zero cause
    `ASSERT_SAME(a_fire_warm, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[3] && (m_tdata[2:1] != 2'b00))
    // fire flag and cause agree
    `ASSERT_SAME(a_fire_cause, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[2:1] == 2'b00)
    // a result is never written over one still waiting
    `ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.decide, !m_tvalid || m_tready)
    // one word in work at a time
    `ASSERT_NEXT(a_busy_after_load, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the windowed loudness trigger core
module tb_top;
    import wlt_pkg::*;

    localparam int DEPTH       = HISTORY_DEPTH_DEF;
    localparam int PKT_MAX     = PACKET_SAMPLES_DEF;
    localparam int LATENCY     = DEPTH + 4;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_WORDS = 500;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [63:0]          ENERGY_MAX       = (64'd1 << ENERGY_W) - 64'd1;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX        = '1;
    localparam logic [LEVEL_W-1:0]   LEVEL_FULL_SCALE = 31'h4000_0000;
    localparam logic [WARMUP_W-1:0]  WARMUP_RST       = 21'(3 * PKT_MAX);
    localparam logic [WARMUP_W-1:0]  WARMUP_ALL       = 21'(DEPTH * PKT_MAX);

    typedef logic [ENERGY_W-1:0]  energy_t;
    typedef logic [SAMPLES_W-1:0] count_t;

    // Result word layout, lowest bit last: fire[0], fire_cause[2:1], warmed_up[3]
    typedef struct packed {
        logic               warmed_up;
        logic [CAUSE_W-1:0] fire_cause;
        logic               fire;
    } verdict_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LEVEL_W-1:0]     cfg_data;

    // Predictor state: history window and register copies
    logic [63:0]    win_energy [DEPTH];
    logic [63:0]    win_samples [DEPTH];
    int             win_slot;
    logic [63:0]    peak_level;
    logic [63:0]    moderate_level;
    logic [63:0]    warmup_total;

    verdict_t       pending_verdicts[$];
    bit             failed;
    int             send_idle_pct;
    int             recv_stall_pct;
    int unsigned    cycle_count;

    windowed_loudness_trigger_core #(
        .HISTORY_DEPTH  (DEPTH),
        .PACKET_SAMPLES (PKT_MAX)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Predict the verdict for one packet and update the window
    function automatic verdict_t judge_packet(input energy_t energy, input count_t count);
        logic [63:0] n;
        logic [63:0] sum_e;
        logic [63:0] sum_n;
        verdict_t    v;
        n = (count > PKT_MAX) ? 64'(PKT_MAX) : 64'(count);
        win_energy[win_slot] = 64'(energy);
        win_samples[win_slot] = n;
        win_slot = (win_slot + 1) % DEPTH;
        sum_e = '0;
        sum_n = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sum_e += win_energy[i];
            sum_n += win_samples[i];
        end
        v = '0;
        if (sum_n < warmup_total)
            return v;
        v.warmed_up = 1'b1;
        if (n != 0 && 64'(energy) >= peak_level * n)
            v.fire_cause = CAUSE_PEAK;
        else if (sum_n != 0 && sum_e >= moderate_level * sum_n)
            v.fire_cause = CAUSE_LONG;
        else
            v.fire_cause = CAUSE_NONE;
        // firing empties the stored energies, counts stay
        if (v.fire_cause != CAUSE_NONE)
        begin
            v.fire = 1'b1;
            for (int i = 0; i < DEPTH; i++)
                win_energy[i] = '0;
        end
        return v;
    endfunction

    // Send one packet word; entered and left at a falling edge
    task automatic send_packet(input energy_t energy, input count_t count);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, count, energy};
        do
            @(posedge clk);
        while (!s_tready);
        pending_verdicts.push_back(judge_packet(energy, count));
        @(negedge clk);
    endtask

    // Hold off until every verdict is back and the core has settled
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Register write; only called while idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [LEVEL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_PEAK:     peak_level = 64'(value);
            CFG_MODERATE: moderate_level = 64'(value);
            CFG_WARMUP:   warmup_total = 64'(value[WARMUP_W-1:0]);
            default:      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly realistic packets, mean power placed around the thresholds
    task automatic send_random_packet;
        count_t      count;
        logic [63:0] n;
        logic [63:0] power;
        logic [63:0] e;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 80)
            count = count_t'(PKT_MAX);
        else if (pick < 90)
            count = count_t'($urandom_range(PKT_MAX));
        else if (pick < 95)
            count = '0;
        else
            count = count_t'($urandom_range(65535, PKT_MAX + 1));
        n = (count > PKT_MAX) ? 64'(PKT_MAX) : 64'(count);
        case ($urandom_range(9))
            0, 1, 2: power = 64'($urandom_range(32'(moderate_level)));
            3, 4:    power = 64'($urandom_range(32'(peak_level), 32'(moderate_level)));
            5:       power = peak_level + 64'($urandom_range(32'(peak_level >> 2) + 1));
            6:       power = peak_level;
            default: power = 64'($urandom_range(32'h0010_0000));
        endcase
        e = power * n;
        // right on or just under the peak boundary
        if (pick % 7 == 0 && e != 0)
            e = e - 64'($urandom_range(1));
        // raw energy over the whole field
        if (pick % 11 == 0)
            e = {$urandom, $urandom} & ENERGY_MAX;
        if (e > ENERGY_MAX)
            e = ENERGY_MAX;
        send_packet(energy_t'(e), count);
    endtask

    // Field extremes, saturation, warm-up edge and both threshold edges
    task automatic test_directed;
        logic [63:0] sum_e;
        logic [63:0] sum_n;
        logic [63:0] gap;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_packet('0, count_t'(47000));
        send_packet(energy_t'(ENERGY_MAX), count_t'(47000));
        // oversized packets saturate, which decides the warm-up edge
        send_packet('0, 16'hFFFF);
        send_packet('0, count_t'(PKT_MAX + 1));
        // peak test exactly met, then just missed
        send_packet(energy_t'(64'(PEAK_LEVEL_RST) * 64'(PKT_MAX)), count_t'(PKT_MAX));
        send_packet(energy_t'(64'(PEAK_LEVEL_RST) * 64'(PKT_MAX) - 1), count_t'(PKT_MAX));
        // empty packet cannot pass the peak test
        send_packet(energy_t'(ENERGY_MAX), '0);
        send_packet(energy_t'(ENERGY_MAX), count_t'(1));
        send_packet('0, '0);
        // long-term test just missed, then exactly met
        for (int k = 1; k >= 0; k--)
        begin
            sum_e = '0;
            sum_n = 64'(PKT_MAX);
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i != win_slot)
                begin
                    sum_e += win_energy[i];
                    sum_n += win_samples[i];
                end
            end
            gap = moderate_level * sum_n;
            gap = (gap >= sum_e + 64'(k)) ? gap - sum_e - 64'(k) : '0;
            send_packet(energy_t'(gap), count_t'(PKT_MAX));
        end
        // alternating bit patterns
        send_packet({23{2'b10}}, 16'h5555);
        send_packet({23{2'b01}}, 16'hAAAA);
        wait_idle();
    endtask

    // Register extremes, empty window and the unused index
    task automatic test_registers;
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        cfg_write(CFG_PEAK, '0);
        cfg_write(CFG_MODERATE, LEVEL_MAX);
        cfg_write(CFG_WARMUP, '0);
        repeat (8) send_random_packet();
        wait_idle();

        // flush the window with empty packets: none can pass the peak test
        cfg_write(CFG_PEAK, LEVEL_MAX);
        cfg_write(CFG_MODERATE, '0);
        repeat (DEPTH) send_packet(energy_t'({$urandom, $urandom}), '0);
        repeat (4) send_random_packet();
        wait_idle();

        // unused index must change nothing; oversized warm-up is cut to its width
        cfg_write(CFG_UNUSED, LEVEL_MAX);
        cfg_write(CFG_PEAK, LEVEL_FULL_SCALE);
        cfg_write(CFG_MODERATE, LEVEL_FULL_SCALE);
        cfg_write(CFG_WARMUP, LEVEL_MAX);
        repeat (10) send_random_packet();
        wait_idle();

        cfg_write(CFG_WARMUP, LEVEL_W'(WARMUP_ALL));
        cfg_write(CFG_UNUSED, '0);
        repeat (40) send_random_packet();
        wait_idle();

        cfg_write(CFG_PEAK, PEAK_LEVEL_RST);
        cfg_write(CFG_MODERATE, MODERATE_LEVEL_RST);
        cfg_write(CFG_WARMUP, LEVEL_W'(WARMUP_RST));
    endtask

    // Random packets over the four idling phases
    task automatic test_random;
        int idle_pct [4];
        int stall_pct [4];
        logic [LEVEL_W-1:0] peak;
        idle_pct  = '{0, 73, 0, 29};
        stall_pct = '{0, 0, 73, 29};
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            if (p != 0)
            begin
                peak = LEVEL_W'($urandom_range(LEVEL_FULL_SCALE, 1000));
                cfg_write(CFG_PEAK, peak);
                cfg_write(CFG_MODERATE, LEVEL_W'($urandom_range(peak)));
                cfg_write(CFG_WARMUP, LEVEL_W'($urandom_range(WARMUP_ALL)));
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // let the pipeline run dry once per phase
                if (i == PHASE_WORDS / 2)
                    wait_idle();
                send_random_packet();
            end
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin : check_result
        verdict_t want;
        verdict_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result word with no packet outstanding: %h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                got  = verdict_t'(m_tdata[3:0]);
                if (got.fire !== want.fire)
                begin
                    $error("fire: expected %0d, got %0d", want.fire, got.fire);
                    failed = 1'b1;
                end
                if (got.fire_cause !== want.fire_cause)
                begin
                    $error("fire_cause: expected %0d, got %0d", want.fire_cause, got.fire_cause);
                    failed = 1'b1;
                end
                if (got.warmed_up !== want.warmed_up)
                begin
                    $error("warmed_up: expected %0d, got %0d", want.warmed_up, got.warmed_up);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PEAK;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        failed         = 1'b0;
        cycle_count    = 0;
        peak_level     = 64'(PEAK_LEVEL_RST);
        moderate_level = 64'(MODERATE_LEVEL_RST);
        warmup_total   = 64'(WARMUP_RST);
        win_slot       = 0;
        win_energy     = '{default: '0};
        win_samples    = '{default: '0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_registers();
        test_random();
        wait_idle();

        if (failed)
            $display("status: fail");
        else
            $display("status: pass");
        $finish;
    end

endmodule
